FILE: design/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg
// Shared types and constants of the vector normalize unit.
// ----------------------------------------------------------------------------
package vn_pkg;

  // Root bits produced by the square root pipeline, one per stage
  localparam int unsigned SQRT_STEPS = 32;
  // Quotient bits produced by each divider pipeline, one per stage
  localparam int unsigned QUO_BITS   = 31;

  // Input request: three signed Q16.16 components
  typedef struct packed {
    logic signed [31:0] x_component;
    logic signed [31:0] y_component;
    logic signed [31:0] z_component;
  } in_t;

  // Result: signed Q2.30 unit components, Q16.16 length, degenerate flag
  typedef struct packed {
    logic signed [31:0] x_unit;
    logic signed [31:0] y_unit;
    logic signed [31:0] z_unit;
    logic        [31:0] vector_length;
    logic               degenerate;
  } out_t;

  // Side data carried alongside the square root pipeline
  typedef struct packed {
    logic [2:0][31:0] mag;
    logic [2:0]       neg;
  } side_t;

endpackage

FILE: design/vn_sqrt.sv
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module vn_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [63:0]       rad_i,
  input  vn_pkg::side_t     side_i,
  output logic              valid_o,
  output logic [31:0]       root_o,
  output vn_pkg::side_t     side_o
);

  localparam int unsigned N = vn_pkg::SQRT_STEPS;

  logic          vld_r  [N+1];
  logic [63:0]   rad_r  [N+1];
  logic [34:0]   rem_r  [N+1];
  logic [31:0]   root_r [N+1];
  vn_pkg::side_t side_r [N+1];

  // Feed stage zero from the inputs
  assign vld_r[0]  = valid_i;
  assign rad_r[0]  = rad_i;
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign side_r[0] = side_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        ge;
    logic [34:0] rem_nxt;
    logic [31:0] root_nxt;

    // Bring in two radicand bits and try the next root bit
    always_comb begin
      rem_sh   = {rem_r[k][32:0], rad_r[k][63:62]};
      trial    = {1'b0, root_r[k], 2'b01};
      ge       = (rem_sh >= trial);
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[k][30:0], ge};
    end

    // Advance valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    // Advance payload
    always_ff @(posedge clk) begin
      rad_r[k+1]  <= {rad_r[k][61:0], 2'b00};
      rem_r[k+1]  <= rem_nxt;
      root_r[k+1] <= root_nxt;
      side_r[k+1] <= side_r[k];
    end
  end

  assign valid_o = vld_r[N];
  assign root_o  = root_r[N];
  assign side_o  = side_r[N];

endmodule

FILE: design/vn_div.sv
// ----------------------------------------------------------------------------
// vn_div
// Pipelined restoring divider for (mag << 30) / len, one quotient bit a stage.
// ----------------------------------------------------------------------------
module vn_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        valid_i,
  input  logic [31:0] mag_i,
  input  logic        neg_i,
  input  logic [31:0] len_i,
  output logic        valid_o,
  output logic [30:0] quo_o,
  output logic        neg_o,
  output logic [31:0] len_o
);

  localparam int unsigned N = vn_pkg::QUO_BITS;

  logic        vld_r [N+1];
  logic [31:0] rem_r [N+1];
  logic [30:0] quo_r [N+1];
  logic        neg_r [N+1];
  logic [31:0] len_r [N+1];

  // Start with the dividend bits above the quotient range (mag <= len)
  assign vld_r[0] = valid_i;
  assign rem_r[0] = {1'b0, mag_i[31:1]};
  assign quo_r[0] = '0;
  assign neg_r[0] = neg_i;
  assign len_r[0] = len_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic        bit_in;
    logic [32:0] rem_sh;
    logic        ge;
    logic [32:0] rem_nxt;

    // Only the first step shifts in a dividend bit; the rest are zero
    if (k == 0) begin : g_first
      assign bit_in = mag_i[0];
    end else begin : g_rest
      assign bit_in = 1'b0;
    end

    // Trial subtract of the divisor
    always_comb begin
      rem_sh  = {rem_r[k], bit_in};
      ge      = (rem_sh >= {1'b0, len_r[k]});
      rem_nxt = ge ? (rem_sh - {1'b0, len_r[k]}) : rem_sh;
    end

    // Advance valid bit
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    // Advance payload
    always_ff @(posedge clk) begin
      rem_r[k+1] <= rem_nxt[31:0];
      quo_r[k+1] <= {quo_r[k][29:0], ge};
      neg_r[k+1] <= neg_r[k];
      len_r[k+1] <= len_r[k];
    end
  end

  assign valid_o = vld_r[N];
  assign quo_o   = quo_r[N];
  assign neg_o   = neg_r[N];
  assign len_o   = len_r[N];

endmodule

FILE: design/vec3_normalize_unit.sv
// ----------------------------------------------------------------------------
// vec3_normalize_unit
// Normalizes a Q16.16 3D vector to Q2.30 unit components, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  ports                     flow control
//  input    start, busy, in_data      request taken when start && !busy
//  result   out_valid, out_data       one-cycle strobe, no back-pressure
//  config   cfg_we, cfg_wdata         min_length written when cfg_we
//
//  One request per cycle; busy is never raised.
//  Pipeline: 3 front stages (magnitude, square, sum), 32 square root
//  stages (one root bit each), 31 divider stages (one quotient bit each) and
//  the output register.
//  Synchronous active-low reset clears all valid bits and min_length.
//  The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module vec3_normalize_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  vn_pkg::in_t  in_data,
  output logic         out_valid,
  output vn_pkg::out_t out_data,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);

  logic [31:0] cfg_min_r;

  logic        s1_vld_r;
  logic [31:0] s1_mag_r [3];
  logic [2:0]  s1_neg_r;
  logic        s2_vld_r;
  logic [63:0] s2_sq_r  [3];
  logic [31:0] s2_mag_r [3];
  logic [2:0]  s2_neg_r;
  logic        s3_vld_r;
  logic [63:0] s3_sum_r;
  vn_pkg::side_t s3_side_r;

  logic [31:0] in_raw [3];
  logic        sq_vld;
  logic [31:0] sq_root;
  vn_pkg::side_t sq_side;

  logic        dv_vld [3];
  logic [30:0] dv_quo [3];
  logic        dv_neg [3];
  logic [31:0] dv_len [3];

  logic         out_valid_r;
  vn_pkg::out_t out_data_r;
  vn_pkg::out_t out_data_nxt;

  assign busy = 1'b0;

  // Hold the threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r <= '0;
    end else if (cfg_we) begin
      cfg_min_r <= cfg_wdata;
    end
  end

  assign in_raw[0] = in_data.x_component;
  assign in_raw[1] = in_data.y_component;
  assign in_raw[2] = in_data.z_component;

  // Front stages: magnitude, square, sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s1_neg_r[i] <= in_raw[i][31];
      s1_mag_r[i] <= in_raw[i][31] ? (32'd0 - in_raw[i]) : in_raw[i];
      s2_sq_r[i]  <= {32'd0, s1_mag_r[i]} * {32'd0, s1_mag_r[i]};
      s2_mag_r[i] <= s1_mag_r[i];
      s2_neg_r[i] <= s1_neg_r[i];
      s3_side_r.mag[i] <= s2_mag_r[i];
      s3_side_r.neg[i] <= s2_neg_r[i];
    end
  end

  always_ff @(posedge clk) begin
    s3_sum_r <= s2_sq_r[0] + s2_sq_r[1] + s2_sq_r[2];
  end

  // Square root of the sum of squares
  vn_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s3_vld_r),
    .rad_i   (s3_sum_r),
    .side_i  (s3_side_r),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // One divider per component
  for (genvar i = 0; i < 3; i++) begin : g_div
    vn_div u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (sq_vld),
      .mag_i   (sq_side.mag[i]),
      .neg_i   (sq_side.neg[i]),
      .len_i   (sq_root),
      .valid_o (dv_vld[i]),
      .quo_o   (dv_quo[i]),
      .neg_o   (dv_neg[i]),
      .len_o   (dv_len[i])
    );
  end

  // Apply sign and degenerate check
  always_comb begin
    logic        degen;
    logic [31:0] q [3];
    logic [31:0] u [3];
    degen = (dv_len[0] <= cfg_min_r);
    for (int i = 0; i < 3; i++) begin
      q[i] = {1'b0, dv_quo[i]};
      u[i] = degen ? 32'd0 : (dv_neg[i] ? (32'd0 - q[i]) : q[i]);
    end
    out_data_nxt.x_unit        = u[0];
    out_data_nxt.y_unit        = u[1];
    out_data_nxt.z_unit        = u[2];
    out_data_nxt.vector_length = dv_len[0];
    out_data_nxt.degenerate    = degen;
  end

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld[0];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/vn_checker.sv
// ----------------------------------------------------------------------------
// vn_checker
// Port-level checks of the vector normalize unit, bound to the top level.
// ----------------------------------------------------------------------------
module vn_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         start,
  input logic         busy,
  input logic         out_valid,
  input vn_pkg::out_t out_data
);

  localparam int unsigned LATENCY = 67;

  // Each request yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("result missing after request");

  // Degenerate results carry zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.degenerate) |->
      (out_data.x_unit == 0 && out_data.y_unit == 0 && out_data.z_unit == 0))
    else $error("degenerate result with nonzero components");

  // Non-degenerate results have a nonzero length
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.degenerate) |-> (out_data.vector_length != 0))
    else $error("zero length not flagged degenerate");

  // Unit components stay within plus or minus one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed(out_data.x_unit) <= 32'sh40000000 &&
       $signed(out_data.x_unit) >= -32'sh40000000 &&
       $signed(out_data.y_unit) <= 32'sh40000000 &&
       $signed(out_data.y_unit) >= -32'sh40000000 &&
       $signed(out_data.z_unit) <= 32'sh40000000 &&
       $signed(out_data.z_unit) >= -32'sh40000000))
    else $error("unit component out of range");

endmodule

bind vec3_normalize_unit vn_checker u_vn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
